// File: hdl/irad_pkg.sv
`timescale 1ns / 1ps
// Shared types for the integer radical block: sequencer states, unit operations
// and the command word passed from the sequencer to the shared arithmetic unit.
// No dependencies.
package irad_pkg;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIVIDE = 6'b000010,
        ST_TEST   = 6'b000100,
        ST_SCALE  = 6'b001000,
        ST_CLOSE  = 6'b010000,
        ST_DONE   = 6'b100000
    } irad_state_t;

    typedef enum logic {
        OP_DIV = 1'b0,
        OP_MUL = 1'b1
    } irad_op_t;

    typedef struct packed {
        logic     start;
        irad_op_t op;
    } irad_cmd_t;

endpackage

// File: hdl/irad_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the integer radical block: one carries the
// operand value, the other the radical. No dependencies.
interface irad_value_if #(parameter int VALUE_WIDTH = 40) ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface irad_radical_if #(parameter int VALUE_WIDTH = 40) ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] radical;

    modport source (output valid, output radical, input ready);
    modport sink   (input valid, input radical, output ready);
endinterface

// File: hdl/irad_unit.sv
`timescale 1ns / 1ps
// Shared bit-serial arithmetic unit: restoring division or shift-add multiply,
// one bit per cycle through a single adder. Depends on irad_pkg.
module irad_unit
    import irad_pkg::*;
#(
    parameter int VALUE_WIDTH = 40
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  irad_cmd_t              cmd,
    input  logic [VALUE_WIDTH-1:0] opnd_a,
    input  logic [VALUE_WIDTH-1:0] opnd_b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] shift_word,
    output logic [VALUE_WIDTH-1:0] acc_word
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    irad_op_t         op_reg;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     shf_reg;
    logic [W-1:0]     opnd_reg;

    logic             bit_in;
    logic [W:0]       add_x;
    logic [W:0]       add_y;
    logic             add_cin;
    logic [W+1:0]     add_sum;
    logic             fits;
    logic [W-1:0]     acc_next;
    logic [W-1:0]     shf_next;

    assign bit_in = shf_reg[W-1];

    // One adder: subtract the divisor, or add the multiplicand when the bit is set
    always_comb
    begin
        if (op_reg == OP_DIV)
        begin
            add_x   = {acc_reg, bit_in};
            add_y   = ~{1'b0, opnd_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_x   = {1'b0, acc_reg[W-2:0], 1'b0};
            add_y   = bit_in ? {1'b0, opnd_reg} : '0;
            add_cin = 1'b0;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, add_cin};
        fits    = add_sum[W+1];

        if (op_reg == OP_DIV)
        begin
            acc_next = fits ? add_sum[W-1:0] : add_x[W-1:0];
            shf_next = {shf_reg[W-2:0], fits};
        end
        else
        begin
            acc_next = add_sum[W-1:0];
            shf_next = {shf_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end
        else if (cmd.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(W - 1);
            op_reg   <= cmd.op;
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg  <= '0;
            shf_reg  <= opnd_b;
            opnd_reg <= opnd_a;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            shf_reg <= shf_next;
        end
    end

    assign done       = done_reg;
    assign shift_word = shf_reg;
    assign acc_word   = acc_reg;

endmodule

// File: hdl/integer_radical.sv
`timescale 1ns / 1ps
// Integer radical by trial division: sequencer around the shared unit, with a
// registered result stage. Depends on irad_pkg, irad_if and irad_unit.
//
// Usage
//   operand (sink): one word carries value, an unsigned integer of at least 1.
//   result (source): one word carries radical, the product of the distinct
//   prime factors of value. Exactly one result word per operand word.
//   operand.ready is high only while the sequencer is idle; one value is
//   factored at a time.
// Operation
//   Every division runs through the shared bit-serial unit and is followed by a
//   state that tests its outcome; each multiply into the product also runs
//   through the unit. A value takes a trial division per divisor tried, one
//   more per prime factor stripped, a multiply per distinct prime stripped and
//   one more multiply when a last prime is left over. operand.ready returns in
//   the same cycle in which the result is presented.
// Reset
//   rst_n clears the sequencer and the result stage; the block comes up idle
//   and ready, with no result pending.
// Stall
//   The result register holds its word until taken. A new operand is accepted
//   while it waits; a later result waits in the final state until the
//   register frees up.
module integer_radical
    import irad_pkg::*;
#(
    parameter int VALUE_WIDTH = 40
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    irad_value_if.sink            operand,
    irad_radical_if.source        result
);

    localparam int W     = VALUE_WIDTH;
    localparam int DIV_W = VALUE_WIDTH / 2 + 1;

    irad_state_t  state_reg,     state_next;
    irad_cmd_t    cmd_reg,       cmd_next;
    logic [W-1:0] opa_reg,       opa_next;
    logic [W-1:0] opb_reg,       opb_next;
    logic [W-1:0] rem_reg,       rem_next;
    logic [DIV_W-1:0] div_reg,   div_next;
    logic [W-1:0] prod_reg,      prod_next;
    logic         counted_reg,   counted_next;
    logic         outer_reg,     outer_next;
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] radical_reg,   radical_next;

    logic         unit_done;
    logic [W-1:0] quot_word;
    logic [W-1:0] acc_word;
    logic [W-1:0] div_wide;
    logic         load_out;

    irad_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_reg),
        .opnd_a     (opa_reg),
        .opnd_b     (opb_reg),
        .done       (unit_done),
        .shift_word (quot_word),
        .acc_word   (acc_word)
    );

    assign div_wide      = W'(div_reg);
    assign operand.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = '{start: 1'b0, op: OP_DIV};
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        prod_next    = prod_reg;
        counted_next = counted_reg;
        outer_next   = outer_reg;
        load_out     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (operand.valid)
                begin
                    // start the first trial: value / 2
                    rem_next     = operand.value;
                    div_next     = DIV_W'(2);
                    prod_next    = W'(1);
                    counted_next = 1'b0;
                    outer_next   = 1'b1;
                    opa_next     = W'(2);
                    opb_next     = operand.value;
                    cmd_next     = '{start: 1'b1, op: OP_DIV};
                    state_next   = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (unit_done)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (outer_reg && (div_wide > quot_word))
                begin
                    // divisor squared exceeds the remainder: what is left is prime or one
                    if (rem_reg > W'(1))
                    begin
                        opa_next   = prod_reg;
                        opb_next   = rem_reg;
                        cmd_next   = '{start: 1'b1, op: OP_MUL};
                        state_next = ST_CLOSE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (acc_word == '0)
                begin
                    // divides: strip one factor, fold it into the product once
                    rem_next   = quot_word;
                    outer_next = 1'b0;
                    if (!counted_reg)
                    begin
                        counted_next = 1'b1;
                        opa_next     = prod_reg;
                        opb_next     = div_wide;
                        cmd_next     = '{start: 1'b1, op: OP_MUL};
                        state_next   = ST_SCALE;
                    end
                    else
                    begin
                        opa_next   = div_wide;
                        opb_next   = quot_word;
                        cmd_next   = '{start: 1'b1, op: OP_DIV};
                        state_next = ST_DIVIDE;
                    end
                end
                else
                begin
                    // advance to the next trial divisor
                    div_next     = div_reg + 1'b1;
                    counted_next = 1'b0;
                    outer_next   = 1'b1;
                    opa_next     = W'(div_reg + 1'b1);
                    opb_next     = rem_reg;
                    cmd_next     = '{start: 1'b1, op: OP_DIV};
                    state_next   = ST_DIVIDE;
                end
            end
            ST_SCALE:
            begin
                if (unit_done)
                begin
                    prod_next  = acc_word;
                    opa_next   = div_wide;
                    opb_next   = rem_reg;
                    cmd_next   = '{start: 1'b1, op: OP_DIV};
                    state_next = ST_DIVIDE;
                end
            end
            ST_CLOSE:
            begin
                if (unit_done)
                begin
                    prod_next  = acc_word;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
            radical_next   = prod_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result.ready;
            radical_next   = radical_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '{start: 1'b0, op: OP_DIV};
            out_valid_reg <= 1'b0;
            counted_reg   <= 1'b0;
            outer_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
            counted_reg   <= counted_next;
            outer_reg     <= outer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        prod_reg    <= prod_next;
        radical_reg <= radical_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.radical = radical_reg;

endmodule

// File: hdl/irad_check.sv
`timescale 1ns / 1ps
// Port-level checks for integer_radical, attached by bind.
// Depends on integer_radical and the irad interfaces.
module irad_check #(
    parameter int VALUE_WIDTH = 40
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   op_valid,
    input logic                   op_ready,
    input logic                   res_valid,
    input logic                   res_ready,
    input logic [VALUE_WIDTH-1:0] res_radical
);

    // one value in flight: ready drops after every accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op_ready |=> !op_ready)
        else $error("operand accepted while a value is being factored");

    // a radical is never zero
    a_radical_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_radical != '0)
        else $error("zero radical presented");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before being taken");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_radical))
        else $error("result changed while stalled");

endmodule

bind integer_radical irad_check #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_irad_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .op_valid    (operand.valid),
    .op_ready    (operand.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_radical (result.radical)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for integer_radical: drives operand words, predicts each radical
// by trial division and checks every result word in order.
// Depends on irad_if and integer_radical from the hdl folder.
module tb_top;

    localparam int VW = 40;
    localparam longint unsigned VALUE_MAX = (64'd1 << VW) - 1;
    localparam int RANDOM_COUNT = 100;
    // Receiver hold-off long enough for the result register and the sequencer to fill.
    localparam int LONG_HOLD = 20000;
    // Cycles to watch for stray results once nothing is expected.
    localparam int DRAIN_CYCLES = 200;
    // Upper bound of the whole run: several times the slowest correct run.
    localparam longint unsigned RUN_LIMIT_NS = 64'd100_000_000;

    // Predicts radicals and holds them until the block returns its own.
    class radical_ledger;
        logic [VW-1:0] pending_radicals[$];
        int            mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Product of the distinct prime factors, by trial division.
        function logic [VW-1:0] radical_of(logic [VW-1:0] value);
            longint unsigned rest;
            longint unsigned divisor;
            longint unsigned prod;
            bit              counted;
            rest    = 64'(value);
            divisor = 2;
            prod    = 1;
            while (divisor <= rest / divisor)
            begin
                counted = 1'b0;
                while (rest % divisor == 0)
                begin
                    if (!counted)
                    begin
                        prod    = (prod * divisor) & VALUE_MAX;
                        counted = 1'b1;
                    end
                    rest = rest / divisor;
                end
                divisor++;
            end
            // Whatever is left above one is a last prime.
            if (rest > 1)
                prod = (prod * rest) & VALUE_MAX;
            return prod[VW-1:0];
        endfunction

        function void note_operand(logic [VW-1:0] value);
            pending_radicals.push_back(radical_of(value));
        endfunction

        function void check_radical(logic [VW-1:0] radical);
            logic [VW-1:0] wanted;
            if (pending_radicals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: radical %0d arrived with none expected", $realtime, radical);
            end
            else
            begin
                wanted = pending_radicals.pop_front();
                if (radical !== wanted)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: radical mismatch, expected %0d, got %0d",
                                 $realtime, wanted, radical);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    irad_value_if   #(.VALUE_WIDTH(VW)) operand_if ();
    irad_radical_if #(.VALUE_WIDTH(VW)) result_if ();

    integer_radical #(.VALUE_WIDTH(VW)) i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_if),
        .result  (result_if)
    );

    radical_ledger ledger = new();

    // Directed words: one and zero, extremes of the field, alternating bits, prime
    // powers, a primorial, a square and a value whose last prime is large.
    logic [VW-1:0] directed_values[] = '{
        40'd1,
        40'd0,
        40'd2,
        40'd3,
        40'd4,
        40'h80_0000_0000,
        40'hFF_FFFF_FFFF,
        40'hAA_AAAA_AAAA,
        40'h55_5555_5555,
        40'd847288609443,
        40'd678223072849,
        40'd200560490130,
        40'd9409,
        40'd1047552,
        40'd19946,
        40'd65536,
        40'd549755715584
    };

    int  radicals_seen;
    int  burst_left;
    bit  long_hold_done;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Hold reset at start, then release it on a rising edge.
    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Mostly values built from small factors, so that trial division ends early; the
    // high bits are reached by multiplying up to a random bit length.
    function automatic logic [VW-1:0] smooth_value();
        longint unsigned v;
        longint unsigned cap;
        longint unsigned f;
        v   = 1;
        cap = (64'd1 << $urandom_range(1, VW)) - 1;
        for (int steps = 0; steps < 64; steps++)
        begin
            f = 64'($urandom_range(2, 97));
            if (v * f > cap)
                break;
            v = v * f;
        end
        // Add a larger last prime now and then.
        if ($urandom_range(0, 1) == 1)
        begin
            f = 64'($urandom_range(2, 9973));
            if (v * f <= VALUE_MAX)
                v = v * f;
        end
        return v[VW-1:0];
    endfunction

    // Offer one word and hold it until taken; at the end of a burst drop valid for a
    // random gap, which may be zero; otherwise keep valid high into the next word.
    task automatic offer_value(input logic [VW-1:0] value);
        int gap;
        operand_if.value <= value;
        operand_if.valid <= 1'b1;
        @(posedge clk);
        while (!operand_if.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                operand_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Sender: directed words, then random ones, then drain and report.
    initial
    begin
        operand_if.valid <= 1'b0;
        operand_if.value <= '0;
        burst_left = $urandom_range(1, 12);
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        foreach (directed_values[i])
            offer_value(directed_values[i]);

        // Open with tiny values so that the block fills during the long hold-off.
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i < 8)
                offer_value(VW'($urandom_range(1, 1000)));
            else
                offer_value(smooth_value());
        end
        operand_if.valid <= 1'b0;

        while (ledger.pending_radicals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.mismatches == 0 && ledger.pending_radicals.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Receiver: a stall pattern of its own, reloaded whenever the slot count wraps; some
    // stretches never stall. Once the directed words are back, hold off for a long
    // stretch so that the input side backs up.
    initial
    begin
        int          slot;
        int          mode;
        logic [15:0] pattern;
        slot    = 0;
        mode    = 0;
        pattern = '1;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && radicals_seen >= directed_values.size())
            begin
                long_hold_done = 1'b1;
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (slot == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    pattern = 16'($urandom);
                end
                case (mode)
                    0:       result_if.ready <= 1'b1;
                    3:       result_if.ready <= pattern[slot] & pattern[(slot + 1) % 16];
                    default: result_if.ready <= pattern[slot];
                endcase
                slot = (slot + 1) % 16;
                @(posedge clk);
            end
        end
    end

    // Note every accepted operand word and check every accepted result word.
    always @(posedge clk)
    begin
        if (rst_n && operand_if.valid && operand_if.ready)
            ledger.note_operand(operand_if.value);
        if (rst_n && result_if.valid && result_if.ready)
        begin
            ledger.check_radical(result_if.radical);
            radicals_seen++;
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/irad_pkg.sv
hdl/irad_if.sv
hdl/irad_unit.sv
hdl/integer_radical.sv
hdl/irad_check.sv
bench/tb_top.sv
